// ===== hdl/bounded_list_push_delete_unit_defines.svh =====
// Assertion macros for the bounded list push/delete unit.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef BOUNDED_LIST_PUSH_DELETE_UNIT_DEFINES_SVH
`define BOUNDED_LIST_PUSH_DELETE_UNIT_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, checked on every rising edge outside reset.
`define BLPD_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("blpd: same-cycle check failed");
// Next-cycle implication, checked on every rising edge outside reset.
`define BLPD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("blpd: next-cycle check failed");
`else
`define BLPD_ASSERT_IMP(lbl, ante, cons)
`define BLPD_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== hdl/blpd_pkg.sv =====
// Shared types and constants for the bounded list push/delete unit.
// No dependencies; every other file of the block but the defines header refers to this package.
package blpd_pkg;

	localparam int CAPACITY_DEF = 64;

	localparam int VALUE_W    = 32;
	localparam int POS_W      = 10;
	localparam int TOTAL_W    = 7;
	localparam int S_TDATA_W  = 48;
	localparam int M_TDATA_W  = 40;

	// Operation codes carried in s_tuser.
	localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
	localparam logic [1:0] OP_PUSH_BACK  = 2'd1;
	localparam logic [1:0] OP_DELETE     = 2'd2;
	localparam logic [1:0] OP_NONE       = 2'd3;

	// One output word as it sits in the output queue.
	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               last;
		logic               empty;
		logic               dropped;
		logic [TOTAL_W-1:0] total;
	} item_t;

	// Sideband that travels with a dump read through the memory latency.
	typedef struct packed {
		logic               valid;
		logic               last;
		logic               empty;
		logic               dropped;
		logic [TOTAL_W-1:0] total;
	} dump_meta_t;

	// Memory port enables from the sequencer.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} mem_ctl_t;

	// Output queue status seen by the sequencer.
	typedef struct packed {
		logic [1:0] count;
		logic       pop;
	} q_stat_t;

endpackage

// ===== hdl/blpd_store.sv =====
// Entry store: one write port and one read port, read data registered.
// Depends on blpd_pkg for the data width.
module blpd_store #(
	parameter int DEPTH = blpd_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                         clk,
	input  blpd_pkg::mem_ctl_t           ctl,
	input  logic [AW-1:0]                wr_addr,
	input  logic [blpd_pkg::VALUE_W-1:0] wr_data,
	input  logic [AW-1:0]                rd_addr,
	output logic [blpd_pkg::VALUE_W-1:0] rd_data
);

	logic [blpd_pkg::VALUE_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/blpd_outq.sv =====
// Two-word output queue that decouples the dump reads from the receiver.
// Depends on blpd_pkg for the item and status types.
module blpd_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  blpd_pkg::dump_meta_t         meta,
	input  logic [blpd_pkg::VALUE_W-1:0] rd_data,
	input  logic                         out_ready,
	output logic                         out_valid,
	output blpd_pkg::item_t              out_item,
	output blpd_pkg::q_stat_t            stat
);

	blpd_pkg::item_t buf_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;
	blpd_pkg::item_t push_item;

	assign push      = meta.valid;
	assign pop       = (count_q != 2'd0) && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign out_item  = buf_q[rd_ptr_q];
	assign stat      = '{count: count_q, pop: pop};

	always_comb begin
		push_item.value   = meta.empty ? '0 : rd_data;
		push_item.last    = meta.last;
		push_item.empty   = meta.empty;
		push_item.dropped = meta.dropped;
		push_item.total   = meta.total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== hdl/blpd_seq.sv =====
// Sequencer: holds front index and count, runs insert, delete shift and dump.
// Depends on blpd_pkg; drives blpd_store and feeds blpd_outq.
module blpd_seq #(
	parameter int CAPACITY = blpd_pkg::CAPACITY_DEF,
	parameter int IW       = $clog2(CAPACITY),
	parameter int CW       = $clog2(CAPACITY + 1)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [1:0]                   in_op,
	input  logic [blpd_pkg::VALUE_W-1:0] in_value,
	input  logic [blpd_pkg::POS_W-1:0]   in_pos,
	output blpd_pkg::mem_ctl_t           mem_ctl,
	output logic [IW-1:0]                wr_addr,
	output logic [blpd_pkg::VALUE_W-1:0] wr_data,
	output logic [IW-1:0]                rd_addr,
	input  logic [blpd_pkg::VALUE_W-1:0] rd_data,
	input  blpd_pkg::q_stat_t            q_stat,
	output blpd_pkg::dump_meta_t         meta_s1
);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_EXEC  = 2'd1;
	localparam logic [1:0] ST_SHIFT = 2'd2;
	localparam logic [1:0] ST_DUMP  = 2'd3;

	localparam logic [CW-1:0] CAP_C  = CW'(CAPACITY);
	localparam logic [IW:0]   CAP_X  = (IW + 1)'(CAPACITY);
	localparam logic [IW-1:0] LAST_S = IW'(CAPACITY - 1);

	logic [1:0]    state_q, state_d;
	logic [IW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic          dropped_q, dropped_d;
	logic [CW-1:0] rd_off_q, rd_off_d;
	logic [IW-1:0] wr_slot_q, wr_slot_d;
	logic [CW-1:0] dump_off_q, dump_off_d;
	logic [IW-1:0] dump_slot_q, dump_slot_d;

	logic [1:0]                   op_q;
	logic [blpd_pkg::VALUE_W-1:0] val_q;
	logic [blpd_pkg::POS_W-1:0]   pos_q;

	logic                 shift_s1, shift_d;
	logic [IW-1:0]        shift_addr_s1, shift_addr_d;
	blpd_pkg::dump_meta_t meta_d;

	logic accept;
	logic can_issue;
	logic last_word;

	// (base + off) modulo CAPACITY, both operands below CAPACITY.
	function automatic logic [IW-1:0] slot_at(input logic [IW-1:0] base,
			input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= CAP_X) begin
			s = s - CAP_X;
		end
		return s[IW-1:0];
	endfunction

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// A read may start only if its word will find room in the queue.
	assign can_issue = ({1'b0, q_stat.count} + {2'b00, meta_s1.valid})
		< (3'd2 + {2'b00, q_stat.pop});
	assign last_word = (dump_off_q == count_q - CW'(1));

	always_comb begin
		state_d      = state_q;
		front_d      = front_q;
		count_d      = count_q;
		dropped_d    = dropped_q;
		rd_off_d     = rd_off_q;
		wr_slot_d    = wr_slot_q;
		dump_off_d   = dump_off_q;
		dump_slot_d  = dump_slot_q;
		shift_d      = 1'b0;
		shift_addr_d = wr_slot_q;
		meta_d       = '0;
		mem_ctl      = '0;
		wr_addr      = shift_addr_s1;
		wr_data      = rd_data;
		rd_addr      = dump_slot_q;

		// Write-back of a shifted entry, in the cycle after its read.
		if (shift_s1) begin
			mem_ctl.wr_en = 1'b1;
		end

		unique case (state_q)
			ST_IDLE: begin
				if (accept && in_op != blpd_pkg::OP_NONE) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d   = ST_DUMP;
				dropped_d = 1'b0;
				unique case (op_q)
					blpd_pkg::OP_PUSH_FRONT, blpd_pkg::OP_PUSH_BACK: begin
						if (count_q == CAP_C) begin
							dropped_d = 1'b1;
						end else begin
							count_d       = count_q + CW'(1);
							mem_ctl.wr_en = 1'b1;
							wr_data       = val_q;
							if (op_q == blpd_pkg::OP_PUSH_FRONT) begin
								front_d = (front_q == '0) ? LAST_S : front_q - IW'(1);
								wr_addr = front_d;
							end else begin
								wr_addr = slot_at(front_q, count_q[IW-1:0]);
							end
						end
					end
					blpd_pkg::OP_DELETE: begin
						if (pos_q >= blpd_pkg::POS_W'(count_q)) begin
							state_d = ST_DUMP;
						end else if (pos_q == '0) begin
							count_d = count_q - CW'(1);
							front_d = (count_q == CW'(1)) ? '0 : slot_at(front_q, IW'(1));
						end else begin
							rd_off_d  = CW'(pos_q) + CW'(1);
							wr_slot_d = slot_at(front_q, pos_q[IW-1:0]);
							state_d   = ST_SHIFT;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
				dump_off_d  = '0;
				dump_slot_d = front_d;
			end
			ST_SHIFT: begin
				// Entry i+1 is read while entry i-1's move is written back.
				if (rd_off_q < count_q) begin
					mem_ctl.rd_en = 1'b1;
					rd_addr       = slot_at(wr_slot_q, IW'(1));
					shift_d       = 1'b1;
					shift_addr_d  = wr_slot_q;
					wr_slot_d     = rd_addr;
					rd_off_d      = rd_off_q + CW'(1);
				end else begin
					count_d     = count_q - CW'(1);
					dump_off_d  = '0;
					dump_slot_d = front_q;
					state_d     = ST_DUMP;
				end
			end
			ST_DUMP: begin
				if (can_issue) begin
					meta_d.valid   = 1'b1;
					meta_d.dropped = dropped_q;
					meta_d.total   = blpd_pkg::TOTAL_W'(count_q);
					if (count_q == '0) begin
						meta_d.empty = 1'b1;
						meta_d.last  = 1'b1;
						state_d      = ST_IDLE;
					end else begin
						mem_ctl.rd_en = 1'b1;
						rd_addr       = dump_slot_q;
						meta_d.last   = last_word;
						dump_off_d    = dump_off_q + CW'(1);
						dump_slot_d   = slot_at(dump_slot_q, IW'(1));
						if (last_word) begin
							state_d = ST_IDLE;
						end
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			front_q   <= '0;
			count_q   <= '0;
			dropped_q <= 1'b0;
			shift_s1  <= 1'b0;
			meta_s1   <= '0;
		end else begin
			state_q   <= state_d;
			front_q   <= front_d;
			count_q   <= count_d;
			dropped_q <= dropped_d;
			shift_s1  <= shift_d;
			meta_s1   <= meta_d;
		end
	end

	always_ff @(posedge clk) begin
		rd_off_q      <= rd_off_d;
		wr_slot_q     <= wr_slot_d;
		dump_off_q    <= dump_off_d;
		dump_slot_q   <= dump_slot_d;
		shift_addr_s1 <= shift_addr_d;
		if (accept) begin
			op_q  <= in_op;
			val_q <= in_value;
			pos_q <= in_pos;
		end
	end

endmodule

// ===== hdl/bounded_list_push_delete_unit.sv =====
// Top level of the bounded list push/delete unit.
// Depends on blpd_pkg, blpd_store, blpd_outq, blpd_seq and the defines header.
//
// The unit keeps an ordered list of up to CAPACITY signed 32-bit values in a
// circular store. Each word on the slave stream (s_*) is one operation,
// selected by s_tuser: push at the front, push at the back, or delete the
// entry at a zero-based position. Operation code three is swallowed without
// any output. Every other operation is followed by a dump of the whole list on
// the master stream (m_*), front first, one word per entry, with m_tlast on
// the final word; an empty list dumps as a single word flagged empty.
// A push into a full list leaves it unchanged and flags every word of its dump.
//
// Timing: a word is taken while idle and executed in the cycle after. A delete
// at position p above zero of a list of n entries then moves the n-p-1 entries
// behind it, one per cycle through the single read and write port of the store,
// and then closes. The dump reads the store at one word per cycle while the
// output queue has room; each read word is registered with its sideband and
// then waits in the output queue for the receiver.
// s_tready is high only while no operation is running; the last dump words may
// still wait in the two-word output queue when the next word is taken.
// If the receiver stalls, the dump pauses and s_tready stays low until the
// last read has been issued. Reset empties the list; the store itself is not
// cleared, since only written entries are ever read.
`include "bounded_list_push_delete_unit_defines.svh"

module bounded_list_push_delete_unit #(
	parameter int CAPACITY = blpd_pkg::CAPACITY_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// [31:0] value, [41:32] position, [47:42] zero
	input  logic [blpd_pkg::S_TDATA_W-1:0] s_tdata,
	// [1:0] op
	input  logic [1:0]                     s_tuser,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// [31:0] item_value, [38:32] entry_total, [39] zero
	output logic [blpd_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] list_empty, [1] insert_dropped
	output logic [1:0]                     m_tuser,
	output logic                           m_tlast
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	blpd_pkg::mem_ctl_t           mem_ctl;
	logic [IW-1:0]                wr_addr;
	logic [blpd_pkg::VALUE_W-1:0] wr_data;
	logic [IW-1:0]                rd_addr;
	logic [blpd_pkg::VALUE_W-1:0] rd_data;
	blpd_pkg::q_stat_t            q_stat;
	blpd_pkg::dump_meta_t         dump_s1;
	blpd_pkg::item_t              out_item;

	blpd_seq #(
		.CAPACITY(CAPACITY),
		.IW      (IW),
		.CW      (CW)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_ready(s_tready),
		.in_op   (s_tuser),
		.in_value(s_tdata[blpd_pkg::VALUE_W-1:0]),
		.in_pos  (s_tdata[blpd_pkg::VALUE_W +: blpd_pkg::POS_W]),
		.mem_ctl (mem_ctl),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.q_stat  (q_stat),
		.meta_s1 (dump_s1)
	);

	blpd_store #(
		.DEPTH(CAPACITY),
		.AW   (IW)
	) u_store (
		.clk    (clk),
		.ctl    (mem_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	blpd_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.meta     (dump_s1),
		.rd_data  (rd_data),
		.out_ready(m_tready),
		.out_valid(m_tvalid),
		.out_item (out_item),
		.stat     (q_stat)
	);

	// Pack the queued word onto the master stream.
	assign m_tdata = {1'b0, out_item.total, out_item.value};
	assign m_tuser = {out_item.dropped, out_item.empty};
	assign m_tlast = out_item.last;

	// A dump read must never arrive at a full queue unless a word leaves.
	`BLPD_ASSERT_IMP(a_queue_room, dump_s1.valid && q_stat.count == 2'd2, q_stat.pop)
	// The shift never writes the entry it is reading in the same cycle.
	`BLPD_ASSERT_IMP(a_no_rw_clash, mem_ctl.wr_en && mem_ctl.rd_en, wr_addr != rd_addr)
	// Any real operation keeps the input closed in the following cycle.
	`BLPD_ASSERT_NEXT(a_busy_after_op,
		s_tvalid && s_tready && s_tuser != blpd_pkg::OP_NONE, !s_tready)
	// An empty dump is a single closing word with a zero count and value.
	`BLPD_ASSERT_IMP(a_empty_word, m_tvalid && m_tuser[0],
		m_tlast && m_tdata[38:0] == 39'd0)

endmodule

// ===== test/bounded_list_push_delete_unit_tb.sv =====
// Self-checking testbench for bounded_list_push_delete_unit: drives list operations on
// the slave stream and checks every dump word on the master stream against a list model.
// Depends on blpd_pkg and the unit itself; needs no files or arguments at run time.
`timescale 1ns / 100ps

module bounded_list_push_delete_unit_tb;

	localparam int LIST_CAP   = blpd_pkg::CAPACITY_DEF;
	localparam int RANDOM_OPS = 440;
	// Cycles with no word moving on either side before the run is abandoned. The slowest
	// correct stretch is a long sender gap, a full-length delete shift and a long receiver
	// stall back to back.
	localparam int IDLE_LIMIT = 3000;
	localparam int DRAIN_WAIT = 200;

	// One operation as it waits to be driven.
	typedef struct {
		logic [1:0]                 op;
		logic [31:0]                value;
		logic [blpd_pkg::POS_W-1:0] position;
	} op_word_t;

	logic                           clk      = 1'b0;
	logic                           arst_n   = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [blpd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
	logic [1:0]                     s_tuser  = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [blpd_pkg::M_TDATA_W-1:0] m_tdata;
	logic [1:0]                     m_tuser;
	logic                           m_tlast;

	bounded_list_push_delete_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	op_word_t        op_pending[$];     // operations still to be driven, oldest first
	logic [31:0]     list_contents[$];  // the list as it should stand, front first
	blpd_pkg::item_t dump_expect_q[$];  // dump words still to arrive, oldest first

	int gen_count;                  // list length as foreseen while building stimulus
	int gen_ops;                    // operations generated, ignored codes not counted
	int fail_count;
	int mismatches;
	int words_checked;
	int n_front, n_back, n_delete, n_ignored, n_refused, n_out_of_range, peak_fill;
	int send_gap, ready_stall, idle_cycles;
	bit send_burst, ready_burst;

	// Mostly short gaps, now and then a long one, and whole stretches with none at all.
	function automatic int pick_gap(inout bit burst);
		int r;
		if ($urandom_range(0, 49) == 0)
			burst = !burst;
		if (burst)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(0, 2);
		else if (r < 95)
			return $urandom_range(3, 8);
		return $urandom_range(15, 40);
	endfunction

	// Values lean towards the extremes of the signed range now and then.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'h0000_0000;
			3: return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Queues one operation and keeps the foreseen list length in step, so that the
	// generator can aim deletes inside or just outside the list.
	task automatic add_op(input logic [1:0] op, input logic [31:0] value,
			input int position);
		op_word_t w;
		w.op       = op;
		w.value    = value;
		w.position = position[blpd_pkg::POS_W-1:0];
		op_pending.push_back(w);
		if (op == blpd_pkg::OP_NONE)
			return;
		gen_ops++;
		if ((op == blpd_pkg::OP_PUSH_FRONT || op == blpd_pkg::OP_PUSH_BACK)
				&& gen_count < LIST_CAP)
			gen_count++;
		else if (op == blpd_pkg::OP_DELETE && position < gen_count)
			gen_count--;
	endtask

	// Picks a delete position: mostly inside the list, with the front, the back and
	// positions just past the end or far beyond it mixed in.
	function automatic int pick_position();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0 || gen_count == 0)
			return (gen_count == 0 && r > 4) ? $urandom_range(0, 1023) : 0;
		if (r == 1)
			return gen_count - 1;
		if (r == 2)
			return gen_count + $urandom_range(0, 3);
		if (r == 3)
			return $urandom_range(0, 1023);
		return $urandom_range(0, gen_count - 1);
	endfunction

	// Applies one accepted operation to the list and queues the dump it must produce.
	task automatic predict_dump(input op_word_t w);
		logic            refused;
		blpd_pkg::item_t e;
		int              n;
		if (w.op == blpd_pkg::OP_NONE) begin
			n_ignored++;
			return;
		end
		refused = 1'b0;
		case (w.op)
			blpd_pkg::OP_PUSH_FRONT: begin
				n_front++;
				if (list_contents.size() >= LIST_CAP)
					refused = 1'b1;
				else
					list_contents.push_front(w.value);
			end
			blpd_pkg::OP_PUSH_BACK: begin
				n_back++;
				if (list_contents.size() >= LIST_CAP)
					refused = 1'b1;
				else
					list_contents.push_back(w.value);
			end
			default: begin
				n_delete++;
				if (w.position < list_contents.size())
					list_contents.delete(w.position);
				else
					n_out_of_range++;
			end
		endcase
		if (refused)
			n_refused++;
		n = list_contents.size();
		if (n > peak_fill)
			peak_fill = n;
		// An empty list still answers with a single word, flagged empty and zero-valued.
		if (n == 0) begin
			e.value   = '0;
			e.last    = 1'b1;
			e.empty   = 1'b1;
			e.dropped = refused;
			e.total   = '0;
			dump_expect_q.push_back(e);
			return;
		end
		for (int i = 0; i < n; i++) begin
			e.value   = list_contents[i];
			e.last    = (i == n - 1);
			e.empty   = 1'b0;
			e.dropped = refused;
			e.total   = n[blpd_pkg::TOTAL_W-1:0];
			dump_expect_q.push_back(e);
		end
	endtask

	task automatic note_mismatch(input string what, input blpd_pkg::item_t want,
			input blpd_pkg::item_t got);
		fail_count++;
		mismatches++;
		if (mismatches <= 10)
			$display({"%t %s: want value %h last %b empty %b dropped %b total %0d,",
				" got value %h last %b empty %b dropped %b total %0d"},
				$realtime, what, want.value, want.last, want.empty, want.dropped,
				want.total, got.value, got.last, got.empty, got.dropped, got.total);
	endtask

	// Sender. The word at the head of op_pending is the one on the bus; it leaves the queue
	// when it is taken, and the next one follows after a random gap.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else begin
			if (s_tvalid && s_tready)
				predict_dump(op_pending.pop_front());
			if (s_tvalid && !s_tready) begin
				// The word stays on the bus until it is taken.
			end else if (send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if (op_pending.size() != 0) begin
				s_tvalid <= 1'b1;
				s_tuser  <= op_pending[0].op;
				s_tdata  <= {{(blpd_pkg::S_TDATA_W - 32 - blpd_pkg::POS_W){1'b0}},
					op_pending[0].position, op_pending[0].value};
				send_gap = pick_gap(send_burst);
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Receiver back-pressure: ready for a while, then stalled for a random spell.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (ready_stall > 0) begin
			ready_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			if ($urandom_range(0, 3) == 0)
				ready_stall = pick_gap(ready_burst);
		end
	end

	// Checker. Every word taken from the master side is compared with the oldest
	// expectation; a word with nothing pending is a failure in its own right.
	always @(posedge clk) begin
		blpd_pkg::item_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.value   = m_tdata[31:0];
			got.total   = m_tdata[32 +: blpd_pkg::TOTAL_W];
			got.last    = m_tlast;
			got.empty   = m_tuser[0];
			got.dropped = m_tuser[1];
			words_checked++;
			if (dump_expect_q.size() == 0)
				note_mismatch("dump word with no dump pending", '0, got);
			else if (got !== dump_expect_q[0])
				note_mismatch("dump word mismatch", dump_expect_q.pop_front(), got);
			else
				void'(dump_expect_q.pop_front());
		end
	end

	// Watchdog: too long with nothing moving on either side means the unit has hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timed out: no word moved for %0d cycles, %0d dump words outstanding.",
					IDLE_LIMIT, dump_expect_q.size());
				$display("bounded_list_push_delete_unit_tb failed");
				$finish;
			end
		end
	end

	initial begin
		int n;
		// Directed part. An ignored code on an idle unit, deletes on an empty list, the
		// extreme values at both ends, deletes at the front, the back, the middle and out
		// of range, and a drain to empty so that the list restarts from a clean front.
		add_op(blpd_pkg::OP_NONE, 32'hdead_beef, 1023);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 0);
		add_op(blpd_pkg::OP_DELETE, 32'hffff_ffff, 1023);
		add_op(blpd_pkg::OP_PUSH_FRONT, 32'h8000_0000, 0);
		add_op(blpd_pkg::OP_PUSH_BACK, 32'h7fff_ffff, 1023);
		add_op(blpd_pkg::OP_PUSH_FRONT, 32'h0000_0000, 341);
		add_op(blpd_pkg::OP_PUSH_BACK, 32'hffff_ffff, 682);
		add_op(blpd_pkg::OP_PUSH_BACK, 32'h5555_5555, 0);
		add_op(blpd_pkg::OP_PUSH_FRONT, 32'haaaa_aaaa, 0);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 1023);
		add_op(blpd_pkg::OP_DELETE, 32'h0, gen_count);
		add_op(blpd_pkg::OP_DELETE, 32'h0, gen_count - 1);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 2);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 0);
		add_op(blpd_pkg::OP_NONE, 32'h1234_5678, 1);
		add_op(blpd_pkg::OP_PUSH_BACK, 32'h0000_0001, 0);
		while (gen_count > 0)
			add_op(blpd_pkg::OP_DELETE, $urandom, 0);
		add_op(blpd_pkg::OP_PUSH_BACK, 32'h1234_5678, 0);
		add_op(blpd_pkg::OP_PUSH_FRONT, 32'hfedc_ba98, 0);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 1);
		add_op(blpd_pkg::OP_DELETE, 32'h0, 0);

		// Random part, built from episodes: fills (often right up to capacity and past it),
		// drains (sometimes all the way to empty), single mixed operations, and noise.
		n = gen_ops + RANDOM_OPS;
		while (gen_ops < n) begin
			case ($urandom_range(0, 9))
				0, 1: begin
					if ($urandom_range(0, 2) == 0)
						repeat (LIST_CAP - gen_count + $urandom_range(1, 4))
							add_op(2'($urandom_range(0, 1)), pick_value(),
								$urandom_range(0, 1023));
					else
						repeat ($urandom_range(1, 12))
							add_op(2'($urandom_range(0, 1)), pick_value(),
								$urandom_range(0, 1023));
				end
				2, 3, 4: begin
					if ($urandom_range(0, 3) == 0)
						repeat (gen_count + 2)
							add_op(blpd_pkg::OP_DELETE, $urandom, pick_position());
					else
						repeat ($urandom_range(1, 12))
							add_op(blpd_pkg::OP_DELETE, $urandom, pick_position());
				end
				5, 6, 7, 8: begin
					if ($urandom_range(0, 1) == 0)
						add_op(2'($urandom_range(0, 1)), pick_value(),
							$urandom_range(0, 1023));
					else
						add_op(blpd_pkg::OP_DELETE, $urandom, pick_position());
				end
				default: begin
					add_op(2'($urandom_range(0, 3)), $urandom, $urandom_range(0, 1023));
				end
			endcase
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (op_pending.size() != 0 || s_tvalid)
			@(posedge clk);
		while (dump_expect_q.size() != 0)
			@(posedge clk);
		// Give any stray words a chance to show up before the verdict.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (dump_expect_q.size() != 0) begin
			fail_count++;
			$display("%0d dump words never arrived.", dump_expect_q.size());
		end

		$display({"Ran %0d front pushes, %0d back pushes, %0d deletes and %0d ignored",
			" codes; %0d dump words checked."},
			n_front, n_back, n_delete, n_ignored, words_checked);
		$display({"%0d pushes refused on a full list, %0d deletes out of range,",
			" peak fill %0d, %0d mismatches."},
			n_refused, n_out_of_range, peak_fill, mismatches);
		if (fail_count == 0)
			$display("bounded_list_push_delete_unit_tb passed");
		else
			$display("bounded_list_push_delete_unit_tb failed");
		$finish;
	end

endmodule
